/* sv/lesq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_pkg
// Shared types, widths and register codes of the largest empty square scan.
// ----------------------------------------------------------------------------
package lesq_pkg;

    localparam int SIZE_W     = 11;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_OUT_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

    typedef logic [SIZE_W-1:0] t_size;

    localparam t_size SIZE_SAT = '1;

    // Position of the cell that is being accepted.
    typedef struct packed {
        logic col_zero;
        logic row_zero;
        logic last_cell;
    } t_pos_tag;

    function automatic t_size min3(input t_size a, input t_size b, input t_size c);
        t_size m;
        m = a;
        if (b < m) begin
            m = b;
        end
        if (c < m) begin
            m = c;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* sv/lesq_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_ifs
// Handshake channels: grid cells in, scan results out, configuration writes.
// ----------------------------------------------------------------------------
interface lesq_cell_if;
    logic valid;
    logic ready;
    logic cell_empty;
    modport source (output valid, output cell_empty, input ready);
    modport sink   (input valid, input cell_empty, output ready);
endinterface

interface lesq_result_if import lesq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SIZE_W-1:0]    best_size;
    logic [COL_OUT_W-1:0] best_col;
    logic [ROW_OUT_W-1:0] best_row;
    modport source (output valid, output best_size, output best_col, output best_row,
                    input ready);
    modport sink   (input valid, input best_size, input best_col, input best_row,
                    output ready);
endinterface

interface lesq_cfg_if import lesq_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* sv/lesq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lesq_ram #(
    parameter int  WIDTH = 11,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/lesq_cursor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_cursor
// Grid size registers and the row/column position of the next cell.
// ----------------------------------------------------------------------------
module lesq_cursor
    import lesq_pkg::*;
#(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lesq_cfg_if.sink      i_cfg,
    input  wire logic     i_accept,
    output logic [CW-1:0] o_col,
    output logic [RW-1:0] o_row,
    output t_pos_tag      o_tag
);

    localparam int WCW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int HCW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_grid_width;
    logic [CFG_DATA_W-1:0] r_grid_height;
    logic [CW-1:0]         r_col;
    logic [RW-1:0]         r_row;

    logic [WCW-1:0] w_ext;
    logic [WCW-1:0] w_eff;
    logic [WCW-1:0] col_inc;
    logic [HCW-1:0] h_ext;
    logic [HCW-1:0] h_eff;
    logic [HCW-1:0] row_inc;
    logic           row_end;
    logic           grid_end;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_DATA_W'(1);
            r_grid_height <= CFG_DATA_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg.data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, and a size beyond the storage saturates.
    always_comb begin
        w_ext = WCW'(r_grid_width);
        h_ext = HCW'(r_grid_height);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = HCW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        col_inc  = WCW'(r_col) + WCW'(1);
        row_inc  = HCW'(r_row) + HCW'(1);
        row_end  = (col_inc >= w_eff);
        grid_end = (row_inc >= h_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col <= '0;
                if (grid_end) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_col           = r_col;
    assign o_row           = r_row;
    assign o_tag.col_zero  = (r_col == '0);
    assign o_tag.row_zero  = (r_row == '0);
    assign o_tag.last_cell = row_end && grid_end;

endmodule
`default_nettype wire

/* sv/lesq_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_update
// Second stage: combines the line store value with the left and diagonal
// neighbors, writes the new side back, tracks the best square, and holds
// the finished result in an output register.
// ----------------------------------------------------------------------------
module lesq_update
    import lesq_pkg::*;
#(
    parameter int  MAX_WIDTH  = 1024,
    parameter int  MAX_HEIGHT = 1024,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_cell_empty,
    input  wire logic [CW-1:0] i_col,
    input  wire logic [RW-1:0] i_row,
    input  wire t_pos_tag      i_tag,
    input  wire t_size         i_rd_data,
    output logic               o_wr_en,
    output logic [CW-1:0]      o_wr_addr,
    output t_size              o_wr_data,
    output logic               o_stall,
    lesq_result_if.source      o_result
);

    logic          r_s1_valid;
    logic          r_s1_empty;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    t_pos_tag      r_s1_tag;
    logic          r_fwd;
    t_size         r_fwd_data;
    t_size         r_left;
    t_size         r_diag;
    t_size         r_best_size;
    logic [COL_OUT_W-1:0] r_best_col;
    logic [ROW_OUT_W-1:0] r_best_row;
    logic          r_out_valid;
    t_size         r_out_size;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [ROW_OUT_W-1:0] r_out_row;

    logic          s1_fire;
    t_size         up_raw;
    t_size         up;
    t_size         left;
    t_size         diag;
    logic [SIZE_W:0] grown;
    t_size         cur;
    logic          better;
    t_size         n_best_size;
    logic [COL_OUT_W-1:0] n_best_col;
    logic [ROW_OUT_W-1:0] n_best_row;

    // A last cell cannot leave while the previous result is still unclaimed.
    assign o_stall = r_s1_valid && r_s1_tag.last_cell && r_out_valid && !o_result.ready;
    assign s1_fire = r_s1_valid && !o_stall;

    always_comb begin
        // With a one-cell row the line store entry was written in the same
        // cycle that it was read, so the bypass register holds the value.
        up_raw = r_fwd ? r_fwd_data : i_rd_data;
        up     = r_s1_tag.row_zero ? '0 : up_raw;
        left   = r_s1_tag.col_zero ? '0 : r_left;
        diag   = (r_s1_tag.row_zero || r_s1_tag.col_zero) ? '0 : r_diag;
        grown  = {1'b0, min3(up, left, diag)} + (SIZE_W + 1)'(1);
        if (!r_s1_empty) begin
            cur = '0;
        end else if (grown[SIZE_W]) begin
            cur = SIZE_SAT;
        end else begin
            cur = grown[SIZE_W-1:0];
        end
        better = (cur > r_best_size);
        if (better) begin
            n_best_size = cur;
            n_best_col  = COL_OUT_W'(r_s1_col);
            n_best_row  = ROW_OUT_W'(r_s1_row);
        end else begin
            n_best_size = r_best_size;
            n_best_col  = r_best_col;
            n_best_row  = r_best_row;
        end
    end

    assign o_wr_en   = s1_fire;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_empty <= i_cell_empty;
            r_s1_col   <= i_col;
            r_s1_row   <= i_row;
            r_s1_tag   <= i_tag;
            r_fwd      <= s1_fire && (r_s1_col == i_col);
            r_fwd_data <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_col  <= '0;
            r_best_row  <= '0;
        end else if (s1_fire) begin
            r_left <= cur;
            r_diag <= up;
            if (r_s1_tag.last_cell) begin
                r_best_size <= '0;
                r_best_col  <= '0;
                r_best_row  <= '0;
            end else begin
                r_best_size <= n_best_size;
                r_best_col  <= n_best_col;
                r_best_row  <= n_best_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_tag.last_cell) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_tag.last_cell) begin
            r_out_size <= n_best_size;
            r_out_col  <= n_best_col;
            r_out_row  <= n_best_row;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.best_size = r_out_size;
    assign o_result.best_col  = r_out_col;
    assign o_result.best_row  = r_out_row;

endmodule
`default_nettype wire

/* sv/largest_empty_square_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// largest_empty_square_scan
// Streams a grid in row-major order and reports the largest all-empty square
// and its bottom-right corner once the last cell of the grid has arrived.
// ----------------------------------------------------------------------------
//  Channel    Role   Payload                          Transaction per
//  i_cell     sink   cell_empty                       grid cell
//  o_result   source best_size, best_col, best_row    completed grid
//  i_cfg      sink   index, data                      register write
//
//  One cell per cycle unless i_cell stalls; each cell passes the line store
//  read and then the update stage, whose read-modify-write sets the rate.
//  A grid's result is registered once its last cell leaves the update stage.
//  Reset is synchronous; the line store needs no clearing pass.
//  i_cell stalls only when a last cell meets an unclaimed previous result.
// ----------------------------------------------------------------------------
module largest_empty_square_scan
    import lesq_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lesq_cell_if.sink     i_cell,
    lesq_result_if.source o_result,
    lesq_cfg_if.sink      i_cfg
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic          accept;
    logic          stall;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    t_pos_tag      tag;
    t_size         rd_data;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    t_size         wr_data;

    assign i_cell.ready = !stall;
    assign accept       = i_cell.valid && i_cell.ready;

    lesq_cursor #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_accept (accept),
        .o_col    (col),
        .o_row    (row),
        .o_tag    (tag)
    );

    lesq_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (col),
        .o_rdata (rd_data)
    );

    lesq_update #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cell_empty (i_cell.cell_empty),
        .i_col        (col),
        .i_row        (row),
        .i_tag        (tag),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_stall      (stall),
        .o_result     (o_result)
    );

endmodule
`default_nettype wire

/* sv/lesq_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lesq_checker
// Port-level checks of the scan block, bound to every instance of it.
// ----------------------------------------------------------------------------
module lesq_checker
    import lesq_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [SIZE_W-1:0]    i_best_size,
    input wire logic [COL_OUT_W-1:0] i_best_col,
    input wire logic [ROW_OUT_W-1:0] i_best_row
);

    // A pending result holds its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_best_size)
            && $stable(i_best_col) && $stable(i_best_row))
        else $error("result changed or vanished while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A new result only follows an earlier cell transaction, since
    // the cell passes the update stage and then the output register.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a cell transaction");

    a_empty_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_best_size == '0) |-> (i_best_col == '0) && (i_best_row == '0))
        else $error("corner reported for a grid without empty cells");

endmodule

bind largest_empty_square_scan lesq_checker u_lesq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_best_size (o_result.best_size),
    .i_best_col  (o_result.best_col),
    .i_best_row  (o_result.best_row)
);
`default_nettype wire

/* tb/sv/lesq_scan_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesq_scan_check_pkg
// Predicts the largest empty square of each streamed grid and checks the
// scan results against those predictions in arrival order.
// ----------------------------------------------------------------------------
package lesq_scan_check_pkg;
    import lesq_pkg::*;

    localparam int GRID_MAX = 1024;

    typedef logic [COL_OUT_W-1:0] t_col;
    typedef logic [ROW_OUT_W-1:0] t_row;

    typedef struct packed {
        t_size side;
        t_col  col;
        t_row  row;
    } t_square;

    class empty_square_scoreboard;
        t_size                 above_sides [GRID_MAX];
        t_size                 left_side;
        t_size                 corner_side;
        t_size                 top_side;
        t_col                  top_col;
        t_row                  top_row;
        int unsigned           scan_col;
        int unsigned           scan_row;
        int unsigned           filled_cols;
        int unsigned           cells_seen;
        int unsigned           grids_done;
        int unsigned           mismatches;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_square               expected_squares [$];

        function new();
            width_reg   = 1;
            height_reg  = 1;
            filled_cols = 0;
            cells_seen  = 0;
            grids_done  = 0;
            mismatches  = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            left_side   = '0;
            corner_side = '0;
            top_side    = '0;
            top_col     = '0;
            top_row     = '0;
            scan_col    = 0;
            scan_row    = 0;
        endfunction

        // A size of zero acts as one, and sizes past the maximum saturate.
        function int unsigned used_size(logic [CFG_DATA_W-1:0] value);
            if (value == 0) begin
                return 1;
            end
            if (value > GRID_MAX) begin
                return GRID_MAX;
            end
            return value;
        endfunction

        function int unsigned pending();
            return expected_squares.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_GRID_WIDTH) begin
                width_reg = data;
            end else if (idx == REG_GRID_HEIGHT) begin
                height_reg = data;
            end
        endfunction

        function void note_cell(logic empty);
            int unsigned cols;
            int unsigned rows;
            int unsigned slot;
            t_size       up;
            t_size       left;
            t_size       diag;
            t_size       side;
            cols = used_size(width_reg);
            rows = used_size(height_reg);
            slot = (scan_col < GRID_MAX) ? scan_col : GRID_MAX - 1;
            up   = (scan_row > 0) ? above_sides[slot] : '0;
            left = (scan_col > 0) ? left_side : '0;
            diag = (scan_row > 0 && scan_col > 0) ? corner_side : '0;
            side = '0;
            if (empty) begin
                side = up;
                if (left < side) begin
                    side = left;
                end
                if (diag < side) begin
                    side = diag;
                end
                side = side + 1'b1;
            end
            // Strictly greater, so the first corner wins a tie.
            if (side > top_side) begin
                top_side = side;
                top_col  = t_col'(scan_col);
                top_row  = t_row'(scan_row);
            end
            above_sides[slot] = side;
            if (slot + 1 > filled_cols) begin
                filled_cols = slot + 1;
            end
            corner_side = up;
            left_side   = side;
            cells_seen++;
            if (scan_col + 1 >= cols) begin
                scan_col = 0;
                if (scan_row + 1 >= rows) begin
                    expected_squares.push_back('{top_side, top_col, top_row});
                    grids_done++;
                    clear_scan();
                end else begin
                    scan_row++;
                end
            end else begin
                scan_col++;
            end
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_size side, t_col col, t_row row);
            t_square want;
            if (expected_squares.size() == 0) begin
                report($sformatf("result %0d/%0d/%0d with no grid completed", side, col, row));
            end else begin
                want = expected_squares.pop_front();
                if (side !== want.side) begin
                    report($sformatf("best_size %0d, expected %0d", side, want.side));
                end
                if (col !== want.col) begin
                    report($sformatf("best_col %0d, expected %0d", col, want.col));
                end
                if (row !== want.row) begin
                    report($sformatf("best_row %0d, expected %0d", row, want.row));
                end
            end
        endtask
    endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams grids of empty and obstacle cells through the largest empty square
// scan under changing grid sizes, idle patterns and output back-pressure, and
// checks every result against a cycle-free prediction of the scan.
// ----------------------------------------------------------------------------
module tb_top;
    import lesq_pkg::*;
    import lesq_scan_check_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lesq_cell_if   cell_ch ();
    lesq_result_if result_ch ();
    lesq_cfg_if    cfg_ch ();

    largest_empty_square_scan #(
        .MAX_WIDTH  (GRID_MAX),
        .MAX_HEIGHT (GRID_MAX)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (cell_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    empty_square_scoreboard board;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    logic        hold_sink      = 1'b0;
    event        hold_start;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering cells.
    always begin
        @(hold_start);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_sink <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            board.check_result(result_ch.best_size, result_ch.best_col, result_ch.best_row);
        end
    end

    always @(posedge i_clk) begin
        if ((cell_ch.valid && cell_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Valid is only lowered when a gap is taken, so a back-to-back transaction
    // never sees valid dropped and raised in the same step.
    task automatic send_cell(input logic empty);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            cell_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_ch.valid      <= 1'b1;
        cell_ch.cell_empty <= empty;
        @(posedge i_clk);
        while (!cell_ch.ready) begin
            @(posedge i_clk);
        end
        board.note_cell(empty);
    endtask

    task automatic send_bits(input int unsigned count, input logic [31:0] pattern);
        for (int i = 0; i < count; i++) begin
            send_cell(pattern[i]);
        end
    endtask

    task automatic quiet_until_drained();
        cell_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        board.write_reg(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] cols,
                            input logic [CFG_DATA_W-1:0] rows);
        set_grid_reg(REG_GRID_WIDTH, cols);
        set_grid_reg(REG_GRID_HEIGHT, rows);
    endtask

    task automatic finish_grid(input int unsigned fill_pct);
        int unsigned start_count;
        start_count = board.grids_done;
        while (board.grids_done == start_count) begin
            send_cell($urandom_range(0, 99) < fill_pct);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 80) begin
            return CFG_DATA_W'($urandom_range(1, 6));
        end
        return CFG_DATA_W'($urandom_range(7, 20));
    endfunction

    task automatic random_grid();
        logic [CFG_DATA_W-1:0] cols;
        logic [CFG_DATA_W-1:0] rows;
        int unsigned           cells;
        int unsigned           fill_pct;
        quiet_until_drained();
        cols = pick_dim();
        rows = pick_dim();
        if (board.used_size(cols) * board.used_size(rows) > 160) begin
            rows = CFG_DATA_W'(160 / board.used_size(cols));
        end
        set_grid(cols, rows);
        case ($urandom_range(0, 3))
            0: fill_pct = 30;
            1: fill_pct = 75;
            2: fill_pct = 92;
            default: fill_pct = 100;
        endcase
        cells = board.used_size(cols) * board.used_size(rows);
        // Now and then resize in the middle of a grid; the counters carry on.
        if (cells > 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, cells - 1)) send_cell($urandom_range(0, 99) < fill_pct);
            quiet_until_drained();
            if ($urandom_range(0, 1) == 0) begin
                cols = CFG_DATA_W'($urandom_range(0, 8));
                // Never widen past the columns the line store has seen.
                if (board.scan_row > 0 && board.used_size(cols) > board.filled_cols) begin
                    cols = CFG_DATA_W'(board.filled_cols);
                end
                set_grid_reg(REG_GRID_WIDTH, cols);
            end else begin
                set_grid_reg(REG_GRID_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
            end
        end
        finish_grid(fill_pct);
    endtask

    initial begin
        int unsigned start_cells;
        int unsigned start_grids;
        board                = new();
        i_rst_n              = 1'b0;
        cell_ch.valid        = 1'b0;
        cell_ch.cell_empty   = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = '0;
        cfg_ch.data          = '0;
        result_ch.ready      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-cell grids at the reset sizes, then sizes of zero.
        send_cell(1'b1);
        send_cell(1'b0);
        quiet_until_drained();
        set_grid(0, 0);
        send_cell(1'b1);
        send_cell(1'b0);
        // No empty cell at all.
        quiet_until_drained();
        set_grid(3, 3);
        send_bits(9, 32'h0);
        quiet_until_drained();
        set_grid(2, 2);
        send_bits(4, 32'hF);
        // Two equal squares: the first corner is kept.
        quiet_until_drained();
        set_grid(3, 2);
        send_bits(6, 32'b000_101);

        // Back-pressure: every cell ends a grid while the receiver holds off.
        quiet_until_drained();
        set_grid(1, 1);
        -> hold_start;
        repeat (40) send_cell($urandom_range(0, 99) < 50);
        quiet_until_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 50;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 50;
                end
                default: begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 31;
                end
            endcase
            start_cells = board.cells_seen;
            start_grids = board.grids_done;
            while (board.cells_seen - start_cells < 170 || board.grids_done - start_grids < 8) begin
                random_grid();
            end
        end

        quiet_until_drained();
        if (board.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
